@@ hdl/allocation_tracker_table_assert.svh @@
// Assertion macros for the allocation tracker table.
// Used by the datapath; needs a clk and an active high rst in scope.
`ifndef ALLOCATION_TRACKER_TABLE_ASSERT_SVH
`define ALLOCATION_TRACKER_TABLE_ASSERT_SVH

// same-cycle implication
`define ATT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ATT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/att_pkg.sv @@
// Shared types and constants of the allocation tracker table.
// No dependencies.
package att_pkg;

  localparam int ENTRIES_DEF      = 64;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 176;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // register indexes
  localparam logic REG_TRACK  = 1'b0;
  localparam logic REG_IGNORE = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } att_cmd_t;

  typedef struct packed {
    logic quick;
    logic scan_end;
    logic clear_end;
    logic out_busy;
  } att_sts_t;

endpackage

@@ hdl/att_ram.sv @@
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/att_ctrl.sv @@
// Controller of the allocation tracker table: clear pass, scan, commit, emit.
// Depends on att_pkg.
module att_ctrl import att_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  att_sts_t sts,
  output att_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_end) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sts.quick ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/att_datapath.sv @@
// Datapath of the allocation tracker table: item registers, table scan,
// counters and output register. Depends on att_pkg and the assertion header.
`include "allocation_tracker_table_assert.svh"
module att_datapath import att_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  localparam int IW = $clog2(ENTRIES),
  localparam int AW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32,
  localparam int MW = 67 + AW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  att_cmd_t              cmd,
  output att_sts_t              sts,
  input  logic                  in_action,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  tracking_enabled,
  input  logic [31:0]           ignored_address,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  ram_we,
  output logic [IW-1:0]         ram_waddr,
  output logic [MW-1:0]         ram_wdata,
  output logic [IW-1:0]         ram_raddr,
  input  logic [MW-1:0]         ram_rdata
);

  localparam int COUNT_W = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ENTRIES);
  // table word: {valid, address, size, kind, stamp}
  localparam int KIND_LO   = 32;
  localparam int SIZE_LO   = 34;
  localparam int ADDR_LO   = 66;
  localparam int VALID_BIT = 66 + AW;

  logic [AW-1:0] in_addr;
  logic [31:0]   in_size;
  logic [1:0]    in_kind;
  logic          quick;
  logic [2:0]    quick_status;

  logic          item_action;
  logic [AW-1:0] item_addr;
  logic [31:0]   item_size;
  logic [1:0]    item_kind;
  logic [2:0]    status_r;
  logic [31:0]   freed_r;

  logic [IW-1:0] idx;
  logic          ev_valid;
  logic [IW-1:0] ev_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_age;
  logic [31:0]   best_size;
  logic [1:0]    best_kind;

  logic [31:0]        alloc_counter;
  logic [31:0]        alloc_bytes;
  logic [31:0]        freed_bytes;
  logic [31:0]        live_byte_sum;
  logic [COUNT_W-1:0] live_count;
  logic [31:0]        live_wide;

  logic          rd_valid;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_size;
  logic [1:0]    rd_kind;
  logic [31:0]   rd_stamp;
  logic [31:0]   age;
  logic          free_hit;

  assign in_addr = in_data[AW-1:0];
  assign in_size = in_data[63:32];
  assign in_kind = in_data[65:64];

  // events settled without a table scan
  always_comb begin
    quick = 1'b0;
    quick_status = ST_OK;
    if (in_action) begin
      if (in_addr == ignored_address[AW-1:0] || !tracking_enabled) begin
        quick = 1'b1;
        quick_status = ST_IGNORED;
      end else if (live_count == '0) begin
        quick = 1'b1;
        quick_status = ST_NOT_FOUND;
      end
    end else begin
      if (!tracking_enabled) begin
        quick = 1'b1;
        quick_status = ST_IGNORED;
      end else if (live_count == FULL_COUNT) begin
        quick = 1'b1;
        quick_status = ST_FULL;
      end
    end
  end

  assign rd_valid = ram_rdata[VALID_BIT];
  assign rd_addr  = ram_rdata[ADDR_LO +: AW];
  assign rd_size  = ram_rdata[SIZE_LO +: 32];
  assign rd_kind  = ram_rdata[KIND_LO +: 2];
  assign rd_stamp = ram_rdata[31:0];
  assign age      = alloc_counter - rd_stamp;
  // newest match has the smallest age
  assign free_hit = rd_valid && (rd_addr == item_addr) && (!found || age < best_age);

  assign sts.quick     = quick;
  assign sts.scan_end  = ev_valid && (item_action ? (ev_idx == LAST) : !rd_valid);
  assign sts.clear_end = (idx == LAST);
  assign sts.out_busy  = out_valid && !out_ready;

  assign ram_raddr = idx;
  assign ram_we    = cmd.clear_wr || (cmd.commit && (!item_action || found));
  assign ram_waddr = cmd.clear_wr ? idx : best_idx;
  assign ram_wdata = cmd.clear_wr ? '0 :
                     {!item_action, item_addr, item_size, item_kind, alloc_counter};

  assign live_wide = 32'(live_count);

  // item, match and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= in_action;
      item_addr   <= in_addr;
      item_size   <= in_size;
      item_kind   <= in_kind;
    end
    if (cmd.scan) begin
      ev_idx <= idx;
    end
    if (cmd.scan && ev_valid) begin
      if (item_action && free_hit) begin
        best_idx  <= ev_idx;
        best_age  <= age;
        best_size <= rd_size;
        best_kind <= rd_kind;
      end else if (!item_action && !rd_valid && !found) begin
        best_idx <= ev_idx;
      end
    end
    if (cmd.emit) begin
      out_data <= {6'd0, live_wide[6:0], live_byte_sum, freed_bytes, alloc_bytes,
                   alloc_counter, freed_r, status_r};
    end
  end

  // control, counters and status
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      ev_valid      <= 1'b0;
      found         <= 1'b0;
      out_valid     <= 1'b0;
      status_r      <= ST_OK;
      freed_r       <= '0;
      alloc_counter <= '0;
      alloc_bytes   <= '0;
      freed_bytes   <= '0;
      live_byte_sum <= '0;
      live_count    <= '0;
    end else begin
      if (cmd.clear_wr) begin
        idx <= (idx == LAST) ? '0 : idx + 1'b1;
      end
      if (cmd.load) begin
        idx      <= '0;
        ev_valid <= 1'b0;
        found    <= 1'b0;
        status_r <= quick_status;
        freed_r  <= '0;
      end
      if (cmd.scan) begin
        ev_valid <= 1'b1;
        if (idx != LAST) idx <= idx + 1'b1;
        if (ev_valid && ((item_action && free_hit) || (!item_action && !rd_valid))) begin
          found <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (!item_action) begin
          status_r      <= ST_OK;
          alloc_counter <= alloc_counter + 32'd1;
          alloc_bytes   <= alloc_bytes + item_size;
          live_byte_sum <= live_byte_sum + item_size;
          live_count    <= live_count + 1'b1;
        end else if (found) begin
          status_r      <= (best_kind == item_kind) ? ST_OK : ST_MISMATCH;
          freed_r       <= best_size;
          freed_bytes   <= freed_bytes + best_size;
          live_byte_sum <= live_byte_sum - best_size;
          live_count    <= live_count - 1'b1;
        end else begin
          status_r <= ST_NOT_FOUND;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ATT_ASSERT_IMP(a_count_bound, 1'b1, live_count <= FULL_COUNT, "live count above table size")
  `ATT_ASSERT_IMP(a_alloc_slot, cmd.commit && !item_action, found, "alloc commit without slot")
  `ATT_ASSERT_NXT(a_alloc_inc, cmd.commit && !item_action,
                  live_count == $past(live_count) + COUNT_W'(1), "alloc did not add entry")

endmodule

@@ hdl/allocation_tracker_table.sv @@
// Allocation tracker table top level: APB registers, controller, datapath, table RAM.
// Ignored, table-full and empty-table events skip the table scan; an allocate scans up to
// the first free slot and a free scans every entry, one entry a cycle through the table
// RAM read port. Result is valid from the cycle the next item can be accepted; a result
// not yet taken holds the next one back. Synchronous reset clears counters and registers,
// then a clearing pass over every entry invalidates the table.
module allocation_tracker_table import att_pkg::*; #(
  parameter int ENTRIES      = ENTRIES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // address[31:0], block_size, alloc_kind, pad
  input  logic                  s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status, freed_size, allocation_count, total_allocated, total_freed,
  // live_bytes, live_entries, pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IW = $clog2(ENTRIES);
  localparam int AW = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
  localparam int MW = 67 + AW;

  logic        tracking_enabled;
  logic [31:0] ignored_address;
  logic        cfg_wr;

  att_cmd_t cmd;
  att_sts_t sts;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [MW-1:0] ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enabled <= 1'b0;
      ignored_address  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TRACK:  tracking_enabled <= pwdata[0];
        REG_IGNORE: ignored_address  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TRACK:  prdata = {31'd0, tracking_enabled};
      REG_IGNORE: prdata = ignored_address;
      default:    prdata = '0;
    endcase
  end

  att_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  att_datapath #(
    .ENTRIES      (ENTRIES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (s_axis_tuser),
    .in_data          (s_axis_tdata),
    .tracking_enabled (tracking_enabled),
    .ignored_address  (ignored_address),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .out_data         (m_axis_tdata),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  att_ram #(
    .WIDTH (MW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
